FILE: hdl/assert_macros.svh
// assert_macros.svh: assertion shorthands sampled on clk, off while arst_n is low.
// No dependencies; taken in by the shader top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define RRPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define RRPS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hdl/rrps_pkg.sv
// rrps_pkg: widths, constants, register indexes and beat types of the
// rounded rectangle pixel shader. No dependencies.
package rrps_pkg;

	localparam int PIXEL_BYTES = 4;
	localparam int FRAC_BITS   = 8;

	localparam int COORD_W   = 12;
	localparam int LEN_W     = 13;
	localparam int RAD_W     = 12;
	localparam int COLOR_W   = 24;
	localparam int CH_W      = 8;
	localparam int NUM_CH    = COLOR_W / CH_W;
	localparam int PITCH_W   = 15;
	localparam int OFS_W     = 26;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;

	localparam int POS_W   = LEN_W + 1;
	localparam int DELTA_W = RAD_W + 1;
	localparam int SQR_W   = 2 * RAD_W;
	localparam int D2_W    = SQR_W + 1;

	localparam int SQRT_IN_W       = D2_W + 2 * FRAC_BITS;
	localparam int ROOT_DIGITS     = (SQRT_IN_W + 1) / 2;
	localparam int DIGITS_PER_STEP = 2;
	localparam int SQRT_STAGES     = (ROOT_DIGITS + DIGITS_PER_STEP - 1) / DIGITS_PER_STEP;
	localparam int ROOT_W          = SQRT_STAGES * DIGITS_PER_STEP;
	localparam int PAD_W           = 2 * ROOT_W;
	localparam int REM_W           = ROOT_W + 2;

	localparam int ALPHA_W = FRAC_BITS + 1;
	localparam int MIX_W   = CH_W + ALPHA_W;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_BITS;

	localparam logic [COORD_W-1:0] RESET_LEFT   = '0;
	localparam logic [COORD_W-1:0] RESET_TOP    = '0;
	localparam logic [LEN_W-1:0]   RESET_WIDTH  = LEN_W'(16);
	localparam logic [LEN_W-1:0]   RESET_HEIGHT = LEN_W'(16);
	localparam logic [RAD_W-1:0]   RESET_RADIUS = '0;
	localparam logic [COLOR_W-1:0] RESET_COLOR  = '0;
	localparam logic [PITCH_W-1:0] RESET_PITCH  = PITCH_W'(4096);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RECT_LEFT    = 3'd0,
		CFG_RECT_TOP     = 3'd1,
		CFG_RECT_WIDTH   = 3'd2,
		CFG_RECT_HEIGHT  = 3'd3,
		CFG_ROUND_RADIUS = 3'd4,
		CFG_INNER_COLOR  = 3'd5,
		CFG_EDGE_COLOR   = 3'd6,
		CFG_ROW_PITCH    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic               write_pixel;
		logic [COLOR_W-1:0] pixel_color;
		logic [OFS_W-1:0]   byte_offset;
	} result_t;

endpackage

FILE: hdl/rounded_rect_pixel_shader_unit.sv
// rounded_rect_pixel_shader_unit: rounded rectangle coverage, rim blend and
// framebuffer offset for one pixel per beat. Depends on rrps_pkg, assert_macros.svh.
//
// Pixel channel: pixel_valid / pixel_stall / pixel_data carry one coordinate
// per beat. Result channel: result_valid / result_stall / result_data carry
// exactly one result per pixel, in order. Configuration: cfg_we writes
// cfg_data into the register at cfg_index in the same edge; write only while
// no pixel is in flight.
// Throughput is one pixel per cycle while result_stall stays low. The depth is
// set by the square root unit, eleven stages of two root digits each, plus six
// stages of window test, squaring, alpha and colour mix.
// Each stage holds its beat while the one after it is full and stuck, so a
// stall on result_stall backs up stage by stage and empty stages keep filling;
// pixel_stall rises only when the first two stages are both full and held.
// Reset empties the pipeline and loads the register reset values: origin 0,
// 16 by 16, radius 0, black colours, pitch 4096.
`include "assert_macros.svh"

module rounded_rect_pixel_shader_unit
	import rrps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	input  pixel_t               pixel_data,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef struct packed {
		logic             write;
		logic             blend;
		logic [OFS_W-1:0] ofs;
	} side_t;

	logic [COORD_W-1:0] left_q;
	logic [COORD_W-1:0] top_q;
	logic [LEN_W-1:0]   width_q;
	logic [LEN_W-1:0]   height_q;
	logic [RAD_W-1:0]   rad_q;
	logic [COLOR_W-1:0] inner_q;
	logic [COLOR_W-1:0] edge_q;
	logic [PITCH_W-1:0] pitch_q;

	logic signed [POS_W-1:0] wmr_q;
	logic signed [POS_W-1:0] hmr_q;
	logic signed [POS_W-1:0] rm1_q;
	logic [SQR_W-1:0]        rr_q;
	logic [SQR_W-1:0]        rm1sq_q;
	logic [RAD_W-1:0]        rad_m1;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s6, vld_s7;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s6, rdy_s7;
	logic vld_s5 [SQRT_STAGES];
	logic rdy_s5 [SQRT_STAGES];

	logic [COORD_W-1:0] x_s1, y_s1;
	logic [POS_W-1:0]   u_s1, v_s1;

	logic                        inside_c, lft_c, rgt_c, top_c, bot_c;
	logic [POS_W-1:0]            dx_c, dy_c;
	logic [COORD_W+PITCH_W-1:0]  row_prod_c;
	logic                        inside_s2;
	logic signed [DELTA_W-1:0]   dx_s2, dy_s2;
	logic [OFS_W-1:0]            ofs_row_s2, ofs_col_s2;

	logic [2*DELTA_W-1:0] sqx_c, sqy_c;
	logic                 inside_s3;
	logic [SQR_W-1:0]     sqx_s3, sqy_s3;
	logic [OFS_W-1:0]     ofs_s3;

	logic             inside_s4;
	logic [D2_W-1:0]  d2_s4;
	logic [OFS_W-1:0] ofs_s4;

	logic [ROOT_W-1:0] root_s5 [SQRT_STAGES];
	logic [REM_W-1:0]  rem_s5  [SQRT_STAGES];
	logic [D2_W-1:0]   d2_s5   [SQRT_STAGES];
	side_t             side_s5 [SQRT_STAGES];

	logic [ROOT_W:0]    rad_fx_c, diff_c;
	logic [ALPHA_W-1:0] alpha_c;
	logic               write_s6;
	logic [OFS_W-1:0]   ofs_s6;
	logic [ALPHA_W-1:0] alpha_s6;

	logic [MIX_W-1:0]   mix_c [NUM_CH];
	logic [COLOR_W-1:0] color_c;
	result_t            res_s7;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= RESET_LEFT;
			top_q    <= RESET_TOP;
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
			rad_q    <= RESET_RADIUS;
			inner_q  <= RESET_COLOR;
			edge_q   <= RESET_COLOR;
			pitch_q  <= RESET_PITCH;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_RECT_LEFT:    left_q   <= cfg_data[COORD_W-1:0];
				CFG_RECT_TOP:     top_q    <= cfg_data[COORD_W-1:0];
				CFG_RECT_WIDTH:   width_q  <= cfg_data[LEN_W-1:0];
				CFG_RECT_HEIGHT:  height_q <= cfg_data[LEN_W-1:0];
				CFG_ROUND_RADIUS: rad_q    <= cfg_data[RAD_W-1:0];
				CFG_INNER_COLOR:  inner_q  <= cfg_data[COLOR_W-1:0];
				CFG_EDGE_COLOR:   edge_q   <= cfg_data[COLOR_W-1:0];
				CFG_ROW_PITCH:    pitch_q  <= cfg_data[PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	// corner geometry derived from the registers
	assign rad_m1 = rad_q - RAD_W'(1);

	always_ff @(posedge clk) begin
		wmr_q   <= POS_W'(width_q) - POS_W'(rad_q);
		hmr_q   <= POS_W'(height_q) - POS_W'(rad_q);
		rm1_q   <= POS_W'(rad_q) - POS_W'(1);
		rr_q    <= SQR_W'(rad_q) * SQR_W'(rad_q);
		rm1sq_q <= SQR_W'(rad_m1) * SQR_W'(rad_m1);
	end

	// stage handshake: a stage loads when empty or when its beat moves on
	assign rdy_s7      = !vld_s7 || !result_stall;
	assign rdy_s6      = !vld_s6 || rdy_s7;
	assign rdy_s4      = !vld_s4 || rdy_s5[0];
	assign rdy_s3      = !vld_s3 || rdy_s4;
	assign rdy_s2      = !vld_s2 || rdy_s3;
	assign rdy_s1      = !vld_s1 || rdy_s2;
	assign pixel_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= pixel_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s6) vld_s6 <= vld_s5[SQRT_STAGES-1];
			if (rdy_s7) vld_s7 <= vld_s6;
		end
	end

	// s1: window-relative position
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			x_s1 <= pixel_data.pixel_x;
			y_s1 <= pixel_data.pixel_y;
			u_s1 <= POS_W'(pixel_data.pixel_x) - POS_W'(left_q);
			v_s1 <= POS_W'(pixel_data.pixel_y) - POS_W'(top_q);
		end
	end

	// s2: window test, corner pick, row offset
	assign inside_c = !u_s1[POS_W-1] && !v_s1[POS_W-1]
		&& (u_s1 < POS_W'(width_q)) && (v_s1 < POS_W'(height_q));
	assign lft_c = u_s1 < POS_W'(rad_q);
	assign top_c = v_s1 < POS_W'(rad_q);
	assign rgt_c = $signed(u_s1) >= wmr_q;
	assign bot_c = $signed(v_s1) >= hmr_q;

	always_comb begin
		dx_c = '0;
		dy_c = '0;
		if (lft_c && top_c) begin
			dx_c = u_s1 - rm1_q;
			dy_c = v_s1 - rm1_q;
		end else if (rgt_c && top_c) begin
			dx_c = u_s1 - wmr_q;
			dy_c = v_s1 - rm1_q;
		end else if (lft_c && bot_c) begin
			dx_c = u_s1 - rm1_q;
			dy_c = v_s1 - hmr_q;
		end else if (rgt_c && bot_c) begin
			dx_c = u_s1 - wmr_q;
			dy_c = v_s1 - hmr_q;
		end
	end

	assign row_prod_c = (COORD_W+PITCH_W)'(y_s1) * (COORD_W+PITCH_W)'(pitch_q);

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			inside_s2  <= inside_c;
			dx_s2      <= dx_c[DELTA_W-1:0];
			dy_s2      <= dy_c[DELTA_W-1:0];
			ofs_row_s2 <= row_prod_c[OFS_W-1:0];
			ofs_col_s2 <= OFS_W'(x_s1) * OFS_W'(PIXEL_BYTES);
		end
	end

	// s3: squares, full offset
	assign sqx_c = (2*DELTA_W)'(dx_s2) * (2*DELTA_W)'(dx_s2);
	assign sqy_c = (2*DELTA_W)'(dy_s2) * (2*DELTA_W)'(dy_s2);

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			inside_s3 <= inside_s2;
			sqx_s3    <= sqx_c[SQR_W-1:0];
			sqy_s3    <= sqy_c[SQR_W-1:0];
			ofs_s3    <= ofs_row_s2 + ofs_col_s2;
		end
	end

	// s4: squared distance
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			inside_s4 <= inside_s3;
			d2_s4     <= D2_W'(sqx_s3) + D2_W'(sqy_s3);
			ofs_s4    <= ofs_s3;
		end
	end

	// s5: square root of d2 scaled by 2^(2*FRAC_BITS), two digits per stage
	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
		logic [ROOT_W-1:0] root_in, root_c;
		logic [REM_W-1:0]  rem_in, rem_c, trial;
		logic [D2_W-1:0]   d2_in;
		logic [PAD_W-1:0]  pad;
		side_t             side_in;
		logic              vld_in, rdy_next;

		if (k == 0) begin : g_head
			assign root_in       = '0;
			assign rem_in        = '0;
			assign d2_in         = d2_s4;
			assign vld_in        = vld_s4;
			assign side_in.write = inside_s4 && !(d2_s4 > D2_W'(rr_q));
			assign side_in.blend = (rad_q == '0) || (d2_s4 > D2_W'(rm1sq_q));
			assign side_in.ofs   = ofs_s4;
		end else begin : g_body
			assign root_in = root_s5[k-1];
			assign rem_in  = rem_s5[k-1];
			assign d2_in   = d2_s5[k-1];
			assign vld_in  = vld_s5[k-1];
			assign side_in = side_s5[k-1];
		end

		if (k == SQRT_STAGES - 1) begin : g_tail
			assign rdy_next = rdy_s6;
		end else begin : g_link
			assign rdy_next = rdy_s5[k+1];
		end

		assign rdy_s5[k] = !vld_s5[k] || rdy_next;
		assign pad = {{(PAD_W - SQRT_IN_W){1'b0}}, d2_in, {(2 * FRAC_BITS){1'b0}}};

		always_comb begin
			root_c = root_in;
			rem_c  = rem_in;
			trial  = '0;
			for (int j = 0; j < DIGITS_PER_STEP; j++) begin
				rem_c = {rem_c[REM_W-3:0],
					pad[PAD_W-1-2*(DIGITS_PER_STEP*k+j) -: 2]};
				trial = {root_c, 2'b01};
				if (rem_c >= trial) begin
					rem_c  = rem_c - trial;
					root_c = {root_c[ROOT_W-2:0], 1'b1};
				end else begin
					root_c = {root_c[ROOT_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s5[k] <= 1'b0;
			end else if (rdy_s5[k]) begin
				vld_s5[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_s5[k]) begin
				root_s5[k] <= root_c;
				rem_s5[k]  <= rem_c;
				d2_s5[k]   <= d2_in;
				side_s5[k] <= side_in;
			end
		end
	end

	// s6: alpha from radius minus distance, clamp to one
	assign rad_fx_c = (ROOT_W+1)'({rad_q, {FRAC_BITS{1'b0}}});
	assign diff_c   = rad_fx_c - {1'b0, root_s5[SQRT_STAGES-1]};

	always_comb begin
		if (!side_s5[SQRT_STAGES-1].blend) begin
			alpha_c = ALPHA_ONE;
		end else if (diff_c[ROOT_W]) begin
			alpha_c = '0;
		end else if (diff_c > (ROOT_W+1)'(ALPHA_ONE)) begin
			alpha_c = ALPHA_ONE;
		end else begin
			alpha_c = diff_c[ALPHA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			write_s6 <= side_s5[SQRT_STAGES-1].write;
			ofs_s6   <= side_s5[SQRT_STAGES-1].ofs;
			alpha_s6 <= alpha_c;
		end
	end

	// s7: per-channel blend, drop colour and offset of unwritten pixels
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			mix_c[c] = MIX_W'(inner_q[c*CH_W +: CH_W]) * MIX_W'(alpha_s6)
				+ MIX_W'(edge_q[c*CH_W +: CH_W]) * MIX_W'(ALPHA_ONE - alpha_s6);
			color_c[c*CH_W +: CH_W] = mix_c[c][FRAC_BITS +: CH_W];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s7) begin
			res_s7.write_pixel <= write_s6;
			res_s7.pixel_color <= write_s6 ? color_c : '0;
			res_s7.byte_offset <= write_s6 ? ofs_s6 : '0;
		end
	end

	assign result_valid = vld_s7;
	assign result_data  = res_s7;

	`RRPS_ASSERT(a_stall_needs_full, !pixel_stall || (vld_s1 && vld_s2), "pixel stall while front stages have room")
	`RRPS_ASSERT_IMPL(a_nowrite_zero, result_valid && !result_data.write_pixel, result_data.pixel_color == '0 && result_data.byte_offset == '0, "unwritten pixel carries colour or offset")
	`RRPS_ASSERT_IMPL(a_alpha_range, vld_s6, alpha_s6 <= ALPHA_ONE, "alpha above one")
	`RRPS_ASSERT_IMPL(a_zero_radius_edge, result_valid && result_data.write_pixel && rad_q == '0, result_data.pixel_color == edge_q, "zero radius pixel not edge colour")

endmodule

FILE: test/rrps_shade_checker.sv
`timescale 1ns / 1ps
// rrps_shade_checker: follows the register, pixel and result ports of the
// rounded rectangle shader, predicts every result beat and compares it field by field.
// Depends on rrps_pkg only.
module rrps_shade_checker
	import rrps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pixel_valid,
	input  logic                 pixel_stall,
	input  pixel_t               pixel_data,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  result_t              result_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   shades_pending,
	output int                   mismatch_count
);

	logic [COORD_W-1:0] rect_left;
	logic [COORD_W-1:0] rect_top;
	logic [LEN_W-1:0]   rect_width;
	logic [LEN_W-1:0]   rect_height;
	logic [RAD_W-1:0]   round_radius;
	logic [COLOR_W-1:0] inner_color;
	logic [COLOR_W-1:0] edge_color;
	logic [PITCH_W-1:0] row_pitch;

	result_t expected_shades[$];
	int      errors;

	function automatic longint unsigned floor_root(longint unsigned val);
		longint unsigned root;
		longint unsigned probe;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > val)
			probe >>= 2;
		while (probe != 0) begin
			if (val >= root + probe) begin
				val -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	function automatic result_t shade_pixel(pixel_t px);
		longint          x, y, u, v, w, h, r, dx, dy, d2;
		longint unsigned rim_len, alpha, one, a, b;
		result_t         shade;
		shade = '0;
		x = longint'(px.pixel_x);
		y = longint'(px.pixel_y);
		w = longint'(rect_width);
		h = longint'(rect_height);
		r = longint'(round_radius);
		u = x - longint'(rect_left);
		v = y - longint'(rect_top);
		dx = 0;
		dy = 0;
		one = 64'd1 << FRAC_BITS;
		if (u < 0 || v < 0 || u >= w || v >= h)
			return shade;
		if (u < r && v < r) begin
			dx = u - (r - 1);
			dy = v - (r - 1);
		end else if (u >= w - r && v < r) begin
			dx = u - (w - r);
			dy = v - (r - 1);
		end else if (u < r && v >= h - r) begin
			dx = u - (r - 1);
			dy = v - (h - r);
		end else if (u >= w - r && v >= h - r) begin
			dx = u - (w - r);
			dy = v - (h - r);
		end
		d2 = dx * dx + dy * dy;
		if (d2 > r * r)
			return shade;
		if (r == 0 || d2 > (r - 1) * (r - 1)) begin
			rim_len = floor_root(longint'(d2) << (2 * FRAC_BITS));
			alpha = (longint'(r) << FRAC_BITS) - rim_len;
			if (alpha > one)
				alpha = one;
		end else begin
			alpha = one;
		end
		shade.write_pixel = 1'b1;
		for (int c = 0; c < NUM_CH; c++) begin
			a = 64'(inner_color[c*CH_W +: CH_W]);
			b = 64'(edge_color[c*CH_W +: CH_W]);
			shade.pixel_color[c*CH_W +: CH_W] = CH_W'((a * alpha + b * (one - alpha)) >> FRAC_BITS);
		end
		shade.byte_offset = OFS_W'(y * longint'(row_pitch) + x * PIXEL_BYTES);
		return shade;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			rect_left = RESET_LEFT;
			rect_top = RESET_TOP;
			rect_width = RESET_WIDTH;
			rect_height = RESET_HEIGHT;
			round_radius = RESET_RADIUS;
			inner_color = RESET_COLOR;
			edge_color = RESET_COLOR;
			row_pitch = RESET_PITCH;
			expected_shades.delete();
			errors = 0;
		end else begin
			if (pixel_valid && !pixel_stall)
				expected_shades.push_back(shade_pixel(pixel_data));
			if (result_valid && !result_stall) begin
				if (expected_shades.size() == 0) begin
					errors++;
					$display("%0t: result beat expected none, actual %h", $time, result_data);
				end else begin
					want = expected_shades.pop_front();
					if (result_data.write_pixel !== want.write_pixel) begin
						errors++;
						$display("%0t: write_pixel expected %0d actual %0d", $time,
							want.write_pixel, result_data.write_pixel);
					end
					if (result_data.pixel_color !== want.pixel_color) begin
						errors++;
						$display("%0t: pixel_color expected %h actual %h", $time,
							want.pixel_color, result_data.pixel_color);
					end
					if (result_data.byte_offset !== want.byte_offset) begin
						errors++;
						$display("%0t: byte_offset expected %h actual %h", $time,
							want.byte_offset, result_data.byte_offset);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_RECT_LEFT:    rect_left = cfg_data[COORD_W-1:0];
					CFG_RECT_TOP:     rect_top = cfg_data[COORD_W-1:0];
					CFG_RECT_WIDTH:   rect_width = cfg_data[LEN_W-1:0];
					CFG_RECT_HEIGHT:  rect_height = cfg_data[LEN_W-1:0];
					CFG_ROUND_RADIUS: round_radius = cfg_data[RAD_W-1:0];
					CFG_INNER_COLOR:  inner_color = cfg_data[COLOR_W-1:0];
					CFG_EDGE_COLOR:   edge_color = cfg_data[COLOR_W-1:0];
					CFG_ROW_PITCH:    row_pitch = cfg_data[PITCH_W-1:0];
					default: ;
				endcase
			end
		end
		shades_pending <= expected_shades.size();
		mismatch_count <= errors;
	end

endmodule

FILE: test/tb_rounded_rect_pixel_shader_unit.sv
`timescale 1ns / 1ps
// tb_rounded_rect_pixel_shader_unit: drives pixel beats and register settings into
// the shader, stalls its result side at random and reports the verdict.
// Depends on rrps_pkg, rounded_rect_pixel_shader_unit and rrps_shade_checker.
module tb_rounded_rect_pixel_shader_unit
	import rrps_pkg::*;
();

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 pixel_valid = 1'b0;
	logic                 pixel_stall;
	pixel_t               pixel_data = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	int                   shades_pending;
	int                   mismatch_count;

	bit idle_on = 1'b1;
	int shape_left, shape_top, shape_width, shape_height, shape_radius;

	rounded_rect_pixel_shader_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_data   (pixel_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	rrps_shade_checker shade_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.pixel_valid    (pixel_valid),
		.pixel_stall    (pixel_stall),
		.pixel_data     (pixel_data),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result_data    (result_data),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.shades_pending (shades_pending),
		.mismatch_count (mismatch_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		result_stall <= idle_on && ($urandom_range(0, 99) < 18);
	end

	task automatic write_reg(input cfg_reg_t idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_shape(input int l, input int t, input int w, input int h, input int r,
			input int inner, input int rim, input int pitch);
		shape_left = l;
		shape_top = t;
		shape_width = w;
		shape_height = h;
		shape_radius = r;
		write_reg(CFG_RECT_LEFT, l);
		write_reg(CFG_RECT_TOP, t);
		write_reg(CFG_RECT_WIDTH, w);
		write_reg(CFG_RECT_HEIGHT, h);
		write_reg(CFG_ROUND_RADIUS, r);
		write_reg(CFG_INNER_COLOR, inner);
		write_reg(CFG_EDGE_COLOR, rim);
		write_reg(CFG_ROW_PITCH, pitch);
	endtask

	// call at a rising edge; returns at the edge where the beat is taken
	task automatic send_pixel(input int x, input int y);
		pixel_t px;
		px.pixel_x = x[COORD_W-1:0];
		px.pixel_y = y[COORD_W-1:0];
		if (idle_on && $urandom_range(0, 99) < 18) begin
			pixel_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_data <= px;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		pixel_valid <= 1'b0;
		do
			@(posedge clk);
		while (shades_pending != 0);
	endtask

	// mostly points on the corner rims and in the box around the shape
	task automatic pick_xy(output int x, output int y);
		int sel, dx, dy, q;
		sel = $urandom_range(0, 99);
		if (sel < 40 && shape_radius > 0) begin
			dx = $urandom_range(0, shape_radius);
			dy = $rtoi($sqrt(real'(shape_radius * shape_radius - dx * dx)));
			dy = dy + int'($urandom_range(0, 2)) - 1;
			q = $urandom_range(0, 3);
			x = q[0] ? shape_left + shape_width - shape_radius + dx
				: shape_left + shape_radius - 1 - dx;
			y = q[1] ? shape_top + shape_height - shape_radius + dy
				: shape_top + shape_radius - 1 - dy;
		end else if (sel < 75) begin
			x = shape_left - 2 + int'($urandom_range(0, shape_width + 3));
			y = shape_top - 2 + int'($urandom_range(0, shape_height + 3));
		end else begin
			x = $urandom_range(0, 4095);
			y = $urandom_range(0, 4095);
		end
	endtask

	initial begin
		int x, y, l, t, w, h, r, lim;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		shape_left = 0;
		shape_top = 0;
		shape_width = 16;
		shape_height = 16;
		shape_radius = 0;
		send_pixel(0, 0);
		send_pixel(15, 15);
		send_pixel(16, 3);
		send_pixel(4095, 4095);
		wait_drained();

		set_shape(100, 50, 64, 40, 10, 24'hFF8000, 24'h0040FF, 16384);
		send_pixel(100, 50);
		send_pixel(100, 59);
		send_pixel(101, 53);
		send_pixel(104, 51);
		send_pixel(163, 50);
		send_pixel(161, 52);
		send_pixel(100, 89);
		send_pixel(102, 87);
		send_pixel(163, 89);
		send_pixel(160, 86);
		send_pixel(130, 70);
		send_pixel(99, 70);
		send_pixel(164, 70);
		send_pixel(130, 49);
		send_pixel(130, 90);
		send_pixel(163, 70);
		wait_drained();

		for (int ph = 0; ph < 12; ph++) begin
			idle_on = !(ph == 6 || ph == 7);
			case (ph)
				0: set_shape(0, 0, 4096, 4096, 2048, 24'hFFFFFF, 24'h000000, 16384);
				1: set_shape(4095, 4095, 8191, 8191, 5, $urandom, $urandom, 32767);
				2: set_shape(10, 10, 0, 50, 3, $urandom, $urandom, $urandom_range(0, 32767));
				3: set_shape(40, 20, 20, 30, 0, $urandom, $urandom, 0);
				4: set_shape(7, 9, 33, 17, 1, $urandom, $urandom, $urandom_range(0, 32767));
				5: set_shape(60, 60, 20, 12, 15, $urandom, $urandom, $urandom_range(0, 32767));
				default: begin
					l = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 400);
					t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 400);
					w = $urandom_range(1, 300);
					h = $urandom_range(1, 300);
					lim = (w < h) ? w : h;
					case ($urandom_range(0, 3))
						0: r = $urandom_range(0, lim / 2);
						1: r = $urandom_range(lim / 2, lim);
						2: r = $urandom_range(0, 4095);
						default: r = $urandom_range(0, 40);
					endcase
					set_shape(l, t, w, h, r, $urandom, $urandom, $urandom_range(0, 32767));
				end
			endcase
			for (int i = 0; i < 70; i++) begin
				if (ph == 3 && i == 35)
					wait_drained();
				pick_xy(x, y);
				send_pixel(x, y);
			end
			wait_drained();
		end

		idle_on = 1'b1;
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && shades_pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/rrps_pkg.sv
hdl/rounded_rect_pixel_shader_unit.sv
test/rrps_shade_checker.sv
test/tb_rounded_rect_pixel_shader_unit.sv
